// ===== rtl/rjpq_pkg.sv =====
`timescale 1ns / 1ps
package rjpq_pkg;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int CostW = 13;
  // full cost reaches 6138, so 13 bits carry the whole value for ordering
  localparam int DivW  = 24;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  from_row;
    logic [9:0]  from_col;
    logic [9:0]  to_row;
    logic [9:0]  to_col;
    logic [15:0] net_code;
    logic [15:0] job_tag;
    logic [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        got_job;
    logic [9:0]  out_from_row;
    logic [9:0]  out_from_col;
    logic [9:0]  out_to_row;
    logic [9:0]  out_to_col;
    logic [15:0] out_net_code;
    logic [15:0] out_tag;
    logic [12:0] job_cost;
    logic [6:0]  jobs_left;
  } out_item_t;

  // one stored job: cells, net, handle, priority and cost
  typedef struct packed {
    logic [39:0]      cells;
    logic [15:0]      net;
    logic [15:0]      handle;
    logic [7:0]       prio;
    logic [CostW-1:0] cost;
  } job_t;

  // command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic pop;
    job_t job;
  } cell_cmd_t;

endpackage

// ===== rtl/rjpq_cost_div.sv =====
`timescale 1ns / 1ps
module rjpq_cost_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [9:0]              dx,
  input  logic [9:0]              dy,
  output logic                    done,
  output logic [rjpq_pkg::CostW-1:0] cost
);
  import rjpq_pkg::*;

  // restoring divide, one quotient bit per cycle
  logic [DivW-1:0]  num_r, num_nxt;
  logic [10:0]      rem_r, rem_nxt;
  logic [9:0]       den_r, den_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             zero_r, zero_nxt;
  logic [9:0]       mx, my;
  logic [11:0]      trial;

  assign mx = (dx > dy) ? dx : dy;
  assign my = (dx > dy) ? dy : dx;
  assign trial = {rem_r, num_r[DivW-1]} ;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    if (start) begin
      num_nxt  = DivW'(({1'b0, dx} + {1'b0, dy}) * ({2'b0, mx} + {1'b0, my, 1'b0}));
      rem_nxt  = '0;
      den_nxt  = mx;
      cnt_nxt  = 5'(DivW);
      busy_nxt = 1'b1;
      zero_nxt = (mx == 10'd0);
    end else if (busy_r) begin
      num_nxt = {num_r[DivW-2:0], 1'b0};
      if (trial >= {2'b0, den_r}) begin
        rem_nxt    = 11'(trial - {2'b0, den_r});
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = 11'(trial);
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign cost = zero_r ? '0 : num_r[CostW-1:0];

endmodule

// ===== rtl/rjpq_cell.sv =====
`timescale 1ns / 1ps
module rjpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  rjpq_pkg::cell_cmd_t cmd,
  input  rjpq_pkg::job_t     left_job,
  input  logic               left_valid,
  input  logic               left_worse,
  input  rjpq_pkg::job_t     right_job,
  input  logic               right_valid,
  output rjpq_pkg::job_t     job,
  output logic               valid,
  output logic               worse
);
  import rjpq_pkg::*;

  job_t job_r, job_nxt;
  logic valid_r, valid_nxt;

  // stored job strictly after the new one
  assign worse = valid_r && ((job_r.prio < cmd.job.prio) ||
                 ((job_r.prio == cmd.job.prio) && (job_r.cost > cmd.job.cost)));

  always_comb begin
    job_nxt   = job_r;
    valid_nxt = valid_r;
    if (cmd.insert) begin
      if (worse) begin
        // shift right: take left neighbour if it also moves, else the new job
        if (left_worse) job_nxt = left_job;
        else job_nxt = cmd.job;
        valid_nxt = 1'b1;
      end else if (!valid_r && left_valid) begin
        // first free cell: grow the list by one
        if (left_worse) job_nxt = left_job;
        else job_nxt = cmd.job;
        valid_nxt = 1'b1;
      end
    end else if (cmd.pop) begin
      job_nxt   = right_job;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (!rst_n || clear) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  assign job   = job_r;
  assign valid = valid_r;

endmodule

// ===== rtl/route_job_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// Routing job list kept in priority order by a row of cells.
// Input channel in_valid/in_stall/in_data carries clear, add or fetch; the
// result channel out_valid/out_stall/out_data returns one result per item.
// An add first runs a restoring cost divider, one quotient bit per cycle,
// then the cost is registered and the job is inserted into the cell row
// where each cell compares against the new key and shifts right as needed;
// a full list returns ST_FULL instead. Clear and fetch act on the row as taken.
// The result is registered. One item is in work at a time: no item is
// accepted while an add runs, and after a clear or fetch the next item is
// accepted unless the result is still held by out_stall.
// Reset empties the list and clears out_valid. While out_valid and out_stall
// are both high, the result is held and no new item is accepted.
module route_job_priority_queue_unit #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rjpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rjpq_pkg::out_item_t out_data
);
  import rjpq_pkg::*;

  localparam int CntW = $clog2(LIST_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  in_item_t        item_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            oval_r, oval_nxt;
  out_item_t       odat_r, odat_nxt;
  logic [CostW-1:0] cost_r;
  logic            take;
  logic            div_start, div_done;
  logic [CostW-1:0] div_cost;
  logic [9:0]      dx, dy;
  cell_cmd_t       cmd;
  logic            clr;
  job_t            cj [LIST_DEPTH];
  logic            cv [LIST_DEPTH];
  logic            cw [LIST_DEPTH];
  logic            full;

  assign in_stall = (state_r != S_IDLE) || (oval_r && out_stall);
  assign take     = in_valid && !in_stall;
  assign full     = (cnt_r == CntW'(LIST_DEPTH));

  assign dx = (in_data.to_col >= in_data.from_col) ? in_data.to_col - in_data.from_col
                                                   : in_data.from_col - in_data.to_col;
  assign dy = (in_data.to_row >= in_data.from_row) ? in_data.to_row - in_data.from_row
                                                   : in_data.from_row - in_data.to_row;
  assign div_start = take && (in_data.kind == KIND_ADD);

  rjpq_cost_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dx(dx), .dy(dy),
    .done(div_done), .cost(div_cost)
  );

  always_comb begin
    cmd.job.cells  = {item_r.from_row, item_r.from_col, item_r.to_row, item_r.to_col};
    cmd.job.net    = item_r.net_code;
    cmd.job.handle = item_r.job_tag;
    cmd.job.prio   = item_r.priority_req;
    cmd.job.cost   = cost_r;
    cmd.insert     = (state_r == S_INS) && !full;
    cmd.pop        = take && (in_data.kind == KIND_FETCH) && (cnt_r != '0);
  end
  assign clr = take && (in_data.kind == KIND_CLEAR);

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    job_t lj, rj;
    logic lv, lw, rv;
    if (g == 0) begin : g_first
      assign lj = cmd.job;
      assign lv = 1'b1;
      assign lw = 1'b0;
    end else begin : g_mid
      assign lj = cj[g-1];
      assign lv = cv[g-1];
      assign lw = cw[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign rj = cmd.job;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rj = cj[g+1];
      assign rv = cv[g+1];
    end
    rjpq_cell u_cell (
      .clk(clk), .rst_n(rst_n), .clear(clr), .cmd(cmd),
      .left_job(lj), .left_valid(lv), .left_worse(lw),
      .right_job(rj), .right_valid(rv),
      .job(cj[g]), .valid(cv[g]), .worse(cw[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = oval_r && out_stall;
    odat_nxt  = odat_r;
    if (take) begin
      unique case (in_data.kind)
        KIND_ADD: state_nxt = S_DIV;
        KIND_CLEAR: begin
          cnt_nxt  = '0;
          oval_nxt = 1'b1;
          odat_nxt = '0;
        end
        KIND_FETCH: begin
          oval_nxt = 1'b1;
          odat_nxt = '0;
          if (cnt_r == '0) begin
            odat_nxt.status = ST_EMPTY;
          end else begin
            odat_nxt.got_job      = 1'b1;
            odat_nxt.out_from_row = cj[0].cells[39:30];
            odat_nxt.out_from_col = cj[0].cells[29:20];
            odat_nxt.out_to_row   = cj[0].cells[19:10];
            odat_nxt.out_to_col   = cj[0].cells[9:0];
            odat_nxt.out_net_code = cj[0].net;
            odat_nxt.out_tag      = cj[0].handle;
            odat_nxt.job_cost     = cj[0].cost;
            cnt_nxt = cnt_r - CntW'(1);
          end
          odat_nxt.jobs_left = 7'(cnt_nxt);
        end
        default: begin
          oval_nxt = 1'b1;
          odat_nxt = '0;
          odat_nxt.jobs_left = 7'(cnt_r);
        end
      endcase
    end else if (state_r == S_DIV) begin
      if (div_done) state_nxt = S_INS;
    end else if (state_r == S_INS) begin
      state_nxt = S_IDLE;
      oval_nxt  = 1'b1;
      odat_nxt  = '0;
      odat_nxt.job_cost = cost_r;
      if (full) odat_nxt.status = ST_FULL;
      else cnt_nxt = cnt_r + CntW'(1);
      odat_nxt.jobs_left = 7'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= in_data;
    if (div_done) cost_r <= div_cost;
    odat_r <= odat_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_valid = oval_r;
  assign out_data  = odat_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(LIST_DEPTH)) else $error("job count beyond depth");
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> cv[0]) else $error("head cell empty with jobs stored");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !take) else $error("item taken during add");
  a_ins_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |=> out_valid) else $error("add gave no result");

endmodule
